[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Each one samples on i_clk and is disabled while
// i_rst_n is low, so modules that use them name their clock and reset so.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

[rtl/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// rtc_pkg
// Types, widths and the multiply sequence table of the ray/triangle
// closest-hit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

    // Field and datapath widths
    localparam int CW          = 32;          // Q16.16 coordinate
    localparam int VW          = CW + 1;      // vertex difference
    localparam int FACE_W      = 16;          // face index field
    localparam int FACE_ID_DEF = 16;          // default face id bits
    localparam int BARY_W      = 17;          // barycentric output
    localparam int PQ_W        = 67;          // cross product component
    localparam int ACC_W       = 102;         // dot product accumulator
    localparam int MP_W        = 34;          // multiplier operand (signed)
    localparam int BIT_W       = $clog2(MP_W);
    localparam int NUM_W       = ACC_W + 16;  // shifted numerator
    localparam int REM_W       = ACC_W + 1;   // divider remainder
    localparam int DCNT_W      = $clog2(NUM_W);
    localparam int RES_W       = 64;          // saturated quotient
    localparam int N_TERMS     = 24;
    localparam int TERM_W      = $clog2(N_TERMS);
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [CW-1:0] ONE_Q   = 32'sd65536;
    localparam logic signed [CW-1:0] CW_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] CW_MIN  = 32'sh8000_0000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_T_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_T_MAX = 3'd7;

    typedef struct packed {
        logic signed [CW-1:0] org_x;
        logic signed [CW-1:0] org_y;
        logic signed [CW-1:0] org_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] t_min;
        logic signed [CW-1:0] t_max;
    } t_cfg;

    // One triangle after the front end: edges, origin offset, tag
    typedef struct packed {
        logic signed [VW-1:0] e1_x;
        logic signed [VW-1:0] e1_y;
        logic signed [VW-1:0] e1_z;
        logic signed [VW-1:0] e2_x;
        logic signed [VW-1:0] e2_y;
        logic signed [VW-1:0] e2_z;
        logic signed [VW-1:0] s_x;
        logic signed [VW-1:0] s_y;
        logic signed [VW-1:0] s_z;
        logic [FACE_W-1:0]    face;
        logic                 last;
    } t_item;

    typedef enum logic [3:0] {
        MC_DIR_X, MC_DIR_Y, MC_DIR_Z,
        MC_S_X, MC_S_Y, MC_S_Z,
        MC_P_X, MC_P_Y, MC_P_Z,
        MC_Q_X, MC_Q_Y, MC_Q_Z
    } t_mc_sel;

    typedef enum logic [3:0] {
        MP_E1_X, MP_E1_Y, MP_E1_Z,
        MP_E2_X, MP_E2_Y, MP_E2_Z,
        MP_S_X, MP_S_Y, MP_S_Z,
        MP_DIR_X, MP_DIR_Y, MP_DIR_Z
    } t_mp_sel;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_P_X, DST_P_Y, DST_P_Z,
        DST_DET, DST_UN,
        DST_Q_X, DST_Q_Y, DST_Q_Z,
        DST_VN, DST_TN
    } t_dst;

    // One product term: acc +/-= mcand * mplier, stored at dst when set
    typedef struct packed {
        t_mc_sel mc;
        t_mp_sel mp;
        logic    sub;
        t_dst    dst;
    } t_term;

    function automatic t_term mk_term(input t_mc_sel mc, input t_mp_sel mp,
                                      input logic sub, input t_dst dst);
        t_term r;
        r.mc  = mc;
        r.mp  = mp;
        r.sub = sub;
        r.dst = dst;
        return r;
    endfunction

    // p = dir x e2, det = e1.p, un = s.p, q = s x e1, vn = dir.q, tn = e2.q
    function automatic t_term term_info(input logic [TERM_W-1:0] idx);
        t_term r;
        case (idx)
            5'd0:    r = mk_term(MC_DIR_Y, MP_E2_Z,  1'b0, DST_NONE);
            5'd1:    r = mk_term(MC_DIR_Z, MP_E2_Y,  1'b1, DST_P_X);
            5'd2:    r = mk_term(MC_DIR_Z, MP_E2_X,  1'b0, DST_NONE);
            5'd3:    r = mk_term(MC_DIR_X, MP_E2_Z,  1'b1, DST_P_Y);
            5'd4:    r = mk_term(MC_DIR_X, MP_E2_Y,  1'b0, DST_NONE);
            5'd5:    r = mk_term(MC_DIR_Y, MP_E2_X,  1'b1, DST_P_Z);
            5'd6:    r = mk_term(MC_P_X,   MP_E1_X,  1'b0, DST_NONE);
            5'd7:    r = mk_term(MC_P_Y,   MP_E1_Y,  1'b0, DST_NONE);
            5'd8:    r = mk_term(MC_P_Z,   MP_E1_Z,  1'b0, DST_DET);
            5'd9:    r = mk_term(MC_P_X,   MP_S_X,   1'b0, DST_NONE);
            5'd10:   r = mk_term(MC_P_Y,   MP_S_Y,   1'b0, DST_NONE);
            5'd11:   r = mk_term(MC_P_Z,   MP_S_Z,   1'b0, DST_UN);
            5'd12:   r = mk_term(MC_S_Y,   MP_E1_Z,  1'b0, DST_NONE);
            5'd13:   r = mk_term(MC_S_Z,   MP_E1_Y,  1'b1, DST_Q_X);
            5'd14:   r = mk_term(MC_S_Z,   MP_E1_X,  1'b0, DST_NONE);
            5'd15:   r = mk_term(MC_S_X,   MP_E1_Z,  1'b1, DST_Q_Y);
            5'd16:   r = mk_term(MC_S_X,   MP_E1_Y,  1'b0, DST_NONE);
            5'd17:   r = mk_term(MC_S_Y,   MP_E1_X,  1'b1, DST_Q_Z);
            5'd18:   r = mk_term(MC_Q_X,   MP_DIR_X, 1'b0, DST_NONE);
            5'd19:   r = mk_term(MC_Q_Y,   MP_DIR_Y, 1'b0, DST_NONE);
            5'd20:   r = mk_term(MC_Q_Z,   MP_DIR_Z, 1'b0, DST_VN);
            5'd21:   r = mk_term(MC_Q_X,   MP_E2_X,  1'b0, DST_NONE);
            5'd22:   r = mk_term(MC_Q_Y,   MP_E2_Y,  1'b0, DST_NONE);
            5'd23:   r = mk_term(MC_Q_Z,   MP_E2_Z,  1'b0, DST_TN);
            default: r = mk_term(MC_DIR_X, MP_E1_X,  1'b0, DST_NONE);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/rtc_front.sv]
// ----------------------------------------------------------------------------
// rtc_front
// Takes triangle requests, forms both edges and the origin offset, masks the
// face id and holds the result until the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_front
    import rtc_pkg::*;
#(
    parameter int FACE_ID_BITS = FACE_ID_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic signed [CW-1:0] i_a_x,
    input  wire logic signed [CW-1:0] i_a_y,
    input  wire logic signed [CW-1:0] i_a_z,
    input  wire logic signed [CW-1:0] i_b_x,
    input  wire logic signed [CW-1:0] i_b_y,
    input  wire logic signed [CW-1:0] i_b_z,
    input  wire logic signed [CW-1:0] i_c_x,
    input  wire logic signed [CW-1:0] i_c_y,
    input  wire logic signed [CW-1:0] i_c_z,
    input  wire logic [FACE_W-1:0]    i_face_index,
    input  wire logic                 i_last_triangle,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output t_item                     o_item
);

    localparam logic [FACE_W-1:0] FACE_MASK = (FACE_ID_BITS >= FACE_W) ?
        {FACE_W{1'b1}} : FACE_W'((64'd1 << FACE_ID_BITS) - 64'd1);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  take;

    // Hand off when the queue has room, refill in the same cycle
    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign take       = i_in_valid && !o_in_stall;
    assign o_item     = r_item;

    // Edge and offset vectors, one extra bit keeps them exact
    always_comb begin
        n_item.e1_x = {i_b_x[CW-1], i_b_x} - {i_a_x[CW-1], i_a_x};
        n_item.e1_y = {i_b_y[CW-1], i_b_y} - {i_a_y[CW-1], i_a_y};
        n_item.e1_z = {i_b_z[CW-1], i_b_z} - {i_a_z[CW-1], i_a_z};
        n_item.e2_x = {i_c_x[CW-1], i_c_x} - {i_a_x[CW-1], i_a_x};
        n_item.e2_y = {i_c_y[CW-1], i_c_y} - {i_a_y[CW-1], i_a_y};
        n_item.e2_z = {i_c_z[CW-1], i_c_z} - {i_a_z[CW-1], i_a_z};
        n_item.s_x  = {i_cfg.org_x[CW-1], i_cfg.org_x} - {i_a_x[CW-1], i_a_x};
        n_item.s_y  = {i_cfg.org_y[CW-1], i_cfg.org_y} - {i_a_y[CW-1], i_a_y};
        n_item.s_z  = {i_cfg.org_z[CW-1], i_cfg.org_z} - {i_a_z[CW-1], i_a_z};
        n_item.face = i_face_index & FACE_MASK;
        n_item.last = i_last_triangle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

[rtl/rtc_queue.sv]
// ----------------------------------------------------------------------------
// rtc_queue
// Two-entry queue between front and back end: a head and a tail register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rtc_queue
    import rtc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    logic [1:0] r_cnt;
    t_item      r_head;
    t_item      r_tail;

    assign o_full  = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        // Data moves toward the head
        if (i_pop) begin
            if (r_cnt == 2'd2) begin
                r_head <= r_tail;
            end else if (i_push) begin
                r_head <= i_item;
            end
            if (i_push && r_cnt == 2'd2) begin
                r_tail <= i_item;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_head <= i_item;
            end else begin
                r_tail <= i_item;
            end
        end
    end

    `ASSERT_IMPLIES(a_push_room, i_push, r_cnt != 2'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_pop_data, i_pop, r_cnt != 2'd0)
    `ASSERT_ALWAYS(a_cnt_range, r_cnt <= 2'(QUEUE_DEPTH))

endmodule

`default_nettype wire

[rtl/rtc_back.sv]
// ----------------------------------------------------------------------------
// rtc_back
// Intersection sequencer: a shared shift-add multiplier walks the product
// table, a restoring divider forms u, v and t, then the closest hit is kept
// and reported on the last triangle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rtc_back
    import rtc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cfg          i_cfg,
    input  wire logic          i_q_valid,
    input  wire t_item         i_q_item,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic               o_hit_found,
    output logic [FACE_W-1:0]  o_hit_face,
    output logic signed [CW-1:0] o_hit_distance,
    output logic [BARY_W-1:0]  o_bary_u,
    output logic [BARY_W-1:0]  o_bary_v
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_MUL, S_DIV_LOAD, S_DIV, S_DECIDE
    } t_state;

    localparam logic [NUM_W-1:0] Q_LIM = NUM_W'(64'h4000_0000_0000_0000);

    t_state                    r_state;
    t_item                     r_item;
    logic [TERM_W-1:0]         r_term;
    logic [BIT_W-1:0]          r_bit;
    logic signed [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]          r_mc;
    logic [MP_W-1:0]           r_mp;
    logic signed [PQ_W-1:0]    r_p_x, r_p_y, r_p_z;
    logic signed [PQ_W-1:0]    r_q_x, r_q_y, r_q_z;
    logic signed [ACC_W-1:0]   r_det, r_un, r_vn, r_tn;
    logic [1:0]                r_div_sel;
    logic [DCNT_W-1:0]         r_dcnt;
    logic [REM_W-1:0]          r_rem;
    logic [NUM_W-1:0]          r_num;
    logic [ACC_W-1:0]          r_dm;
    logic                      r_neg;
    logic signed [RES_W-1:0]   r_u, r_v, r_t;
    logic                      r_any;
    logic signed [CW-1:0]      r_best_dist;
    logic [FACE_W-1:0]         r_best_face;
    logic [BARY_W-1:0]         r_best_u, r_best_v;
    logic                      r_out_valid;

    t_term                     term;
    logic signed [ACC_W-1:0]   mc_val;
    logic signed [MP_W-1:0]    mp_val;
    logic [ACC_W-1:0]          addend;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   num_sel;
    logic signed [NUM_W-1:0]   num_wide;
    logic [REM_W-1:0]          rem_sh;
    logic                      ge;
    logic [NUM_W-1:0]          q_full;
    logic [RES_W-1:0]          q_mag;
    logic signed [RES_W-1:0]   q_res;
    logic signed [CW-1:0]      t32;
    logic                      hit_ok;
    logic                      take;
    logic                      emit;
    logic                      n_any;
    logic signed [CW-1:0]      n_dist;
    logic [FACE_W-1:0]         n_face;
    logic [BARY_W-1:0]         n_u, n_v;

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;

    // Operand selection for the current product term
    always_comb begin
        term = term_info(r_term);
        case (term.mc)
            MC_DIR_X: mc_val = ACC_W'(i_cfg.dir_x);
            MC_DIR_Y: mc_val = ACC_W'(i_cfg.dir_y);
            MC_DIR_Z: mc_val = ACC_W'(i_cfg.dir_z);
            MC_S_X:   mc_val = ACC_W'(r_item.s_x);
            MC_S_Y:   mc_val = ACC_W'(r_item.s_y);
            MC_S_Z:   mc_val = ACC_W'(r_item.s_z);
            MC_P_X:   mc_val = ACC_W'(r_p_x);
            MC_P_Y:   mc_val = ACC_W'(r_p_y);
            MC_P_Z:   mc_val = ACC_W'(r_p_z);
            MC_Q_X:   mc_val = ACC_W'(r_q_x);
            MC_Q_Y:   mc_val = ACC_W'(r_q_y);
            MC_Q_Z:   mc_val = ACC_W'(r_q_z);
            default:  mc_val = '0;
        endcase
        case (term.mp)
            MP_E1_X:  mp_val = MP_W'(r_item.e1_x);
            MP_E1_Y:  mp_val = MP_W'(r_item.e1_y);
            MP_E1_Z:  mp_val = MP_W'(r_item.e1_z);
            MP_E2_X:  mp_val = MP_W'(r_item.e2_x);
            MP_E2_Y:  mp_val = MP_W'(r_item.e2_y);
            MP_E2_Z:  mp_val = MP_W'(r_item.e2_z);
            MP_S_X:   mp_val = MP_W'(r_item.s_x);
            MP_S_Y:   mp_val = MP_W'(r_item.s_y);
            MP_S_Z:   mp_val = MP_W'(r_item.s_z);
            MP_DIR_X: mp_val = MP_W'(i_cfg.dir_x);
            MP_DIR_Y: mp_val = MP_W'(i_cfg.dir_y);
            MP_DIR_Z: mp_val = MP_W'(i_cfg.dir_z);
            default:  mp_val = '0;
        endcase
    end

    // Shift-add step; the multiplier's top bit carries negative weight
    always_comb begin
        addend = r_mp[0] ? r_mc : '0;
        if ((r_bit == BIT_W'(MP_W - 1)) ^ term.sub) begin
            acc_next = r_acc - ACC_W'(addend);
        end else begin
            acc_next = r_acc + ACC_W'(addend);
        end
    end

    // Divider operands and one restoring step
    always_comb begin
        case (r_div_sel)
            2'd0:    num_sel = r_un;
            2'd1:    num_sel = r_vn;
            default: num_sel = r_tn;
        endcase
        num_wide = {num_sel, 16'b0};
        rem_sh   = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
        ge       = (rem_sh >= {1'b0, r_dm});
        q_full   = {r_num[NUM_W-2:0], ge};
        q_mag    = (q_full > Q_LIM) ? RES_W'(Q_LIM) : RES_W'(q_full);
        q_res    = r_neg ? -RES_W'(q_mag) : RES_W'(q_mag);
    end

    // Acceptance tests and closest-hit update
    always_comb begin
        if (r_t > RES_W'(CW_MAX)) begin
            t32 = CW_MAX;
        end else if (r_t < RES_W'(CW_MIN)) begin
            t32 = CW_MIN;
        end else begin
            t32 = r_t[CW-1:0];
        end
        hit_ok = (r_det != '0)
              && !r_u[RES_W-1] && (r_u <= RES_W'(ONE_Q))
              && !r_v[RES_W-1] && ((r_u + r_v) <= RES_W'(ONE_Q))
              && (t32 >= i_cfg.t_min) && (t32 <= i_cfg.t_max);
        take   = hit_ok && (!r_any || (t32 < r_best_dist));
        n_any  = r_any || take;
        n_dist = take ? t32 : r_best_dist;
        n_face = take ? r_item.face : r_best_face;
        n_u    = take ? r_u[BARY_W-1:0] : r_best_u;
        n_v    = take ? r_v[BARY_W-1:0] : r_best_v;
        emit   = r_item.last && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_any       <= 1'b0;
            r_best_dist <= CW_MAX;
            r_best_face <= '0;
            r_best_u    <= '0;
            r_best_v    <= '0;
        end else begin
            // Result register: load on emit, free once taken
            if (r_state == S_DECIDE && emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_term  <= '0;
                        r_acc   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_mc    <= mc_val;
                    r_mp    <= mp_val;
                    r_bit   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_mc  <= r_mc << 1;
                    r_mp  <= r_mp >> 1;
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == BIT_W'(MP_W - 1) && term.dst != DST_NONE) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= acc_next;
                    end
                    if (r_bit == BIT_W'(MP_W - 1)) begin
                        case (term.dst)
                            DST_P_X: r_p_x <= PQ_W'(acc_next);
                            DST_P_Y: r_p_y <= PQ_W'(acc_next);
                            DST_P_Z: r_p_z <= PQ_W'(acc_next);
                            DST_DET: r_det <= acc_next;
                            DST_UN:  r_un  <= acc_next;
                            DST_Q_X: r_q_x <= PQ_W'(acc_next);
                            DST_Q_Y: r_q_y <= PQ_W'(acc_next);
                            DST_Q_Z: r_q_z <= PQ_W'(acc_next);
                            DST_VN:  r_vn  <= acc_next;
                            DST_TN:  r_tn  <= acc_next;
                            default: ;
                        endcase
                        if (r_term == TERM_W'(N_TERMS - 1)) begin
                            r_div_sel <= 2'd0;
                            r_state   <= S_DIV_LOAD;
                        end else begin
                            r_term  <= r_term + 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DIV_LOAD: begin
                    // A zero determinant is a miss, no division needed
                    if (r_det == '0) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_neg   <= num_wide[NUM_W-1] ^ r_det[ACC_W-1];
                        r_num   <= num_wide[NUM_W-1] ? NUM_W'(-num_wide)
                                                     : NUM_W'(num_wide);
                        r_dm    <= r_det[ACC_W-1] ? ACC_W'(-r_det) : ACC_W'(r_det);
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? (rem_sh - {1'b0, r_dm}) : rem_sh;
                    r_num  <= q_full;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCNT_W'(NUM_W - 1)) begin
                        case (r_div_sel)
                            2'd0:    r_u <= q_res;
                            2'd1:    r_v <= q_res;
                            default: r_t <= q_res;
                        endcase
                        if (r_div_sel == 2'd2) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_div_sel <= r_div_sel + 1'b1;
                            r_state   <= S_DIV_LOAD;
                        end
                    end
                end
                S_DECIDE: begin
                    if (!r_item.last) begin
                        r_any       <= n_any;
                        r_best_dist <= n_dist;
                        r_best_face <= n_face;
                        r_best_u    <= n_u;
                        r_best_v    <= n_v;
                        r_state     <= S_IDLE;
                    end else if (emit) begin
                        // Report and start a new mesh
                        o_hit_found    <= n_any;
                        o_hit_face     <= n_face;
                        o_hit_distance <= n_dist;
                        o_bary_u       <= n_u;
                        o_bary_v       <= n_v;
                        r_any          <= 1'b0;
                        r_best_dist    <= CW_MAX;
                        r_best_face    <= '0;
                        r_best_u       <= '0;
                        r_best_v       <= '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_pop_idle, o_q_pop, r_state == S_IDLE)
    `ASSERT_IMPLIES(a_bit_range, r_state == S_MUL, r_bit <= BIT_W'(MP_W - 1))
    `ASSERT_NEXT(a_emit_clears, r_state == S_DECIDE && emit, r_out_valid && !r_any)

endmodule

`default_nettype wire

[rtl/ray_triangle_closest_hit.sv]
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit
// Closest-hit ray/triangle test (Moller-Trumbore) over a stream of triangles
// in signed Q16.16, with exact products and truncating division.
// ----------------------------------------------------------------------------
// Usage:
//   Write the ray origin, direction and distance window through the config
//   port (index 0..7) while the block is idle. Send triangles on the input
//   channel (valid/stall); a request is taken when valid is high and stall
//   is low. Mark the last triangle of a mesh; after it the block sends one
//   result on the output channel with the closest hit (earlier face wins a
//   tie), or hit_found low, and clears its hit state.
//   In the back end each triangle runs 24 product terms on the shared
//   shift-add multiplier, then three restoring divisions. A zero
//   determinant skips the divisions. The front register and a two-entry
//   queue hold up to three more triangles while one is worked on.
//   Reset loads the default ray (along +z, window 0 to max) and clears the
//   hit state. A stalled result holds; the block keeps working on later
//   triangles and only waits if another result is ready before it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_closest_hit
    import rtc_pkg::*;
#(
    parameter int FACE_ID_BITS = FACE_ID_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CW-1:0]         i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic signed [CW-1:0]  i_a_x,
    input  wire logic signed [CW-1:0]  i_a_y,
    input  wire logic signed [CW-1:0]  i_a_z,
    input  wire logic signed [CW-1:0]  i_b_x,
    input  wire logic signed [CW-1:0]  i_b_y,
    input  wire logic signed [CW-1:0]  i_b_z,
    input  wire logic signed [CW-1:0]  i_c_x,
    input  wire logic signed [CW-1:0]  i_c_y,
    input  wire logic signed [CW-1:0]  i_c_z,
    input  wire logic [FACE_W-1:0]     i_face_index,
    input  wire logic                  i_last_triangle,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_hit_found,
    output logic [FACE_W-1:0]          o_hit_face,
    output logic signed [CW-1:0]       o_hit_distance,
    output logic [BARY_W-1:0]          o_bary_u,
    output logic [BARY_W-1:0]          o_bary_v
);

    t_cfg  r_cfg;
    logic  q_full;
    logic  push;
    t_item f_item;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.org_x <= '0;
            r_cfg.org_y <= '0;
            r_cfg.org_z <= '0;
            r_cfg.dir_x <= '0;
            r_cfg.dir_y <= '0;
            r_cfg.dir_z <= ONE_Q;
            r_cfg.t_min <= '0;
            r_cfg.t_max <= CW_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORG_X: r_cfg.org_x <= i_cfg_data;
                CFG_ORG_Y: r_cfg.org_y <= i_cfg_data;
                CFG_ORG_Z: r_cfg.org_z <= i_cfg_data;
                CFG_DIR_X: r_cfg.dir_x <= i_cfg_data;
                CFG_DIR_Y: r_cfg.dir_y <= i_cfg_data;
                CFG_DIR_Z: r_cfg.dir_z <= i_cfg_data;
                CFG_T_MIN: r_cfg.t_min <= i_cfg_data;
                CFG_T_MAX: r_cfg.t_max <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    rtc_front #(
        .FACE_ID_BITS (FACE_ID_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_a_x           (i_a_x),
        .i_a_y           (i_a_y),
        .i_a_z           (i_a_z),
        .i_b_x           (i_b_x),
        .i_b_y           (i_b_y),
        .i_b_z           (i_b_z),
        .i_c_x           (i_c_x),
        .i_c_y           (i_c_y),
        .i_c_z           (i_c_z),
        .i_face_index    (i_face_index),
        .i_last_triangle (i_last_triangle),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_item          (f_item)
    );

    rtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    rtc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit_found    (o_hit_found),
        .o_hit_face     (o_hit_face),
        .o_hit_distance (o_hit_distance),
        .o_bary_u       (o_bary_u),
        .o_bary_v       (o_bary_v)
    );

endmodule

`default_nettype wire
